>>> rtl/charge_state_led_strip_animator_defines.svh
// assertion macros for the charge state led strip animator
`ifndef CHARGE_STATE_LED_STRIP_ANIMATOR_DEFINES_SVH
`define CHARGE_STATE_LED_STRIP_ANIMATOR_DEFINES_SVH

// same-cycle implication
`define CSLA_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define CSLA_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/csla_pkg.sv
// shared types, codes and color tables for the led strip animator
`timescale 1ns / 1ps
package csla_pkg;

  localparam int PIXELS_DEF = 8;
  localparam int LIT_W      = 7;
  localparam int PHASE_W    = 5;

  localparam logic [1:0] MODE_DISC = 2'd0;
  localparam logic [1:0] MODE_CHG  = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  localparam logic [1:0] STAT_DISC = 2'd0;
  localparam logic [1:0] STAT_CHG  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [2:0] OP_ALL    = 3'd0;
  localparam logic [2:0] OP_EDGES  = 3'd1;
  localparam logic [2:0] OP_CENTER = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_LEFT   = 3'd4;

  localparam logic [7:0] COLOR_MIN = 8'd10;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [2:0]       op;
    rgb_t             color;
    logic [LIT_W-1:0] lit_len;
    logic             act;
    logic             rot;
  } cell_ctl_t;

  function automatic rgb_t mk(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rgb_t c;
    c.r = r;
    c.g = g;
    c.b = b;
    return c;
  endfunction

  function automatic rgb_t warm_color(input logic [3:0] p);
    logic [7:0] v;
    v = 8'd10 + 8'({p, 2'b00}) + 8'(p);
    return mk(8'd0, v, v);
  endfunction

  function automatic rgb_t pulse_color(input logic [2:0] k);
    rgb_t c;
    case (k)
      3'd0:    c = mk(8'd255, 8'd0, 8'd127);
      3'd1:    c = mk(8'd205, 8'd0, 8'd103);
      3'd2:    c = mk(8'd155, 8'd0, 8'd78);
      3'd3:    c = mk(8'd105, 8'd0, 8'd53);
      default: c = mk(8'd55, 8'd0, 8'd28);
    endcase
    return c;
  endfunction

  function automatic rgb_t wave_color(input logic [4:0] p);
    rgb_t c;
    case (p)
      5'd0, 5'd19:  c = mk(8'd10, 8'd40, 8'd0);
      5'd1, 5'd18:  c = mk(8'd15, 8'd60, 8'd0);
      5'd2, 5'd17:  c = mk(8'd30, 8'd115, 8'd0);
      5'd3, 5'd16:  c = mk(8'd40, 8'd149, 8'd0);
      5'd4, 5'd15:  c = mk(8'd45, 8'd180, 8'd0);
      5'd5, 5'd14:  c = mk(8'd51, 8'd206, 8'd0);
      5'd6, 5'd13:  c = mk(8'd55, 8'd227, 8'd0);
      5'd7, 5'd12:  c = mk(8'd60, 8'd242, 8'd0);
      5'd8, 5'd11:  c = mk(8'd62, 8'd251, 8'd0);
      5'd9, 5'd10:  c = mk(8'd65, 8'd255, 8'd0);
      default:      c = mk(8'd10, 8'd40, 8'd0);
    endcase
    return c;
  endfunction

endpackage

>>> rtl/csla_cell.sv
// one pixel cell of the strip shift chain
`timescale 1ns / 1ps
module csla_cell
  import csla_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF,
  parameter int IDX    = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  rgb_t      left_i,
  input  rgb_t      right_i,
  output rgb_t      pix_o,
  output logic      bright_o
);

  localparam int EDGE_H   = (PIXELS + 1) / 2;
  localparam int CENTER_H = PIXELS / 2;
  localparam logic [LIT_W-1:0] IDX_L = LIT_W'(IDX);

  rgb_t pix_r, pix_nxt;

  always_comb begin
    pix_nxt = pix_r;
    if (ctl.rot) begin
      pix_nxt = right_i;
    end else if (ctl.act) begin
      case (ctl.op)
        OP_ALL: begin
          pix_nxt = ctl.color;
        end
        OP_EDGES: begin
          if (IDX < EDGE_H) begin
            pix_nxt = (IDX == 0) ? ctl.color : left_i;
          end else begin
            pix_nxt = (IDX == PIXELS - 1) ? ctl.color : right_i;
          end
        end
        OP_CENTER: begin
          // odd strip: the center cell and the one to its right both take the color directly
          if (IDX >= CENTER_H) begin
            pix_nxt = (IDX == CENTER_H || (PIXELS % 2 == 1 && IDX == CENTER_H + 1)) ?
                      ctl.color : left_i;
          end else begin
            pix_nxt = (IDX == PIXELS - 1 - CENTER_H) ? ctl.color : right_i;
          end
        end
        OP_RIGHT: begin
          if (IDX_L < ctl.lit_len) begin
            pix_nxt = (IDX == 0) ? ctl.color : left_i;
          end
        end
        OP_LEFT: begin
          if (IDX_L < ctl.lit_len) begin
            pix_nxt = (IDX_L == ctl.lit_len - 1'b1) ? ctl.color : right_i;
          end
        end
        default: begin
          pix_nxt = pix_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_o    = pix_r;
  assign bright_o = (pix_r.r > COLOR_MIN) || (pix_r.g > COLOR_MIN) || (pix_r.b > COLOR_MIN);

endmodule

>>> rtl/charge_state_led_strip_animator.sv
// led strip animator: charger status and beat sequencer over a chain of pixel cells
// Usage:
//   in_* channel takes one request per handshake. in_tuser = 1 is a beat, 0 a
//   charger status update. A status request is absorbed in ST_IDLE and gives
//   no output. A beat commits the pending mode when its number is a multiple
//   of 80, updates the strip in ST_ACT, folds the power flag in ST_PWR,
//   then streams all PIXELS pixels on out_*, index 0 first, one per cycle
//   while out_tready is high, out_tlast on the final pixel.
//   The first pixel appears on out_* once the strip has passed ST_ACT and ST_PWR.
//   No new request is taken until a beat's last pixel has gone; beat length
//   is set by the single output port that the cell chain rotates past, one
//   pixel a cycle while out_tready is high.
//   in_tready is low while a beat is in progress. When the receiver stalls,
//   the current pixel is held and the chain does not rotate.
//   Reset (rst_n low, synchronous) clears the strip to black, both modes to
//   disconnected, phase, percent and lit length to zero.
`timescale 1ns / 1ps
module charge_state_led_strip_animator
  import csla_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // chg_status[1:0], battery_percent[9:2], beat_number[25:10]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
  output logic        out_tlast,
  output logic        out_tuser   // strip_power
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACT  = 2'd1;
  localparam logic [1:0] ST_PWR  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int DIV   = 100 / PIXELS;
  localparam int RECIP = (65536 + DIV - 1) / DIV;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         cur_mode_r, cur_mode_nxt;
  logic [1:0]         pend_mode_r, pend_mode_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         pct_r, pct_nxt;
  logic [LIT_W-1:0]   lit_r, lit_nxt;
  logic [5:0]         idx_r, idx_nxt;
  logic               power_r, power_nxt;

  logic [1:0]  in_status;
  logic [7:0]  in_pct;
  logic [15:0] in_beat;
  logic        in_fire, out_fire, beat_commit;
  logic [23:0] len_prod;
  logic [7:0]  len_quot;
  logic [LIT_W-1:0] len_val;
  logic        last_idx;

  cell_ctl_t ctl;
  rgb_t      pix [PIXELS];
  logic [PIXELS-1:0] bright;

  assign in_status = in_tdata[1:0];
  assign in_pct    = in_tdata[9:2];
  assign in_beat   = in_tdata[25:10];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_fire  = out_tvalid && out_tready;
  assign last_idx  = (idx_r == 6'(PIXELS - 1));

  // multiple of 80: low nibble zero and upper 12 bits divisible by 5 (16 = 1 mod 5)
  function automatic logic div80(input logic [15:0] v);
    logic [5:0] s1;
    logic [4:0] s2;
    logic [4:0] s3;
    s1 = 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
    s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
    s3 = 5'(s2[4]) + 5'(s2[3:0]);
    return (v[3:0] == 4'd0) &&
           (s3 == 5'd0 || s3 == 5'd5 || s3 == 5'd10 || s3 == 5'd15);
  endfunction

  assign beat_commit = div80(in_beat);

  // percent over the per-pixel step by reciprocal multiply, exact for 0..100
  assign len_prod = 24'(pct_r) * 24'(RECIP);
  assign len_quot = len_prod[23:16];

  always_comb begin
    if (pct_r == 8'd0) begin
      len_val = '0;
    end else if (pct_r > 8'd100 || len_quot > 8'(PIXELS)) begin
      len_val = LIT_W'(PIXELS);
    end else begin
      len_val = len_quot[LIT_W-1:0];
    end
  end

  always_comb begin
    ctl.act     = (state_r == ST_ACT);
    ctl.rot     = out_fire;
    ctl.lit_len = lit_r;
    ctl.op      = OP_ALL;
    ctl.color   = '0;
    case (cur_mode_r)
      MODE_DISC: begin
        if (phase_r < 5'd9) begin
          ctl.op    = OP_ALL;
          ctl.color = warm_color(phase_r[3:0]);
        end else if (phase_r < 5'd14) begin
          ctl.op    = OP_EDGES;
          ctl.color = pulse_color(3'(phase_r - 5'd9));
        end else begin
          ctl.op    = OP_EDGES;
          ctl.color = '0;
        end
      end
      MODE_CHG: begin
        ctl.op    = OP_RIGHT;
        ctl.color = wave_color(phase_r);
      end
      MODE_FULL: begin
        ctl.op    = OP_CENTER;
        ctl.color = wave_color(phase_r);
      end
      default: begin
        ctl.op    = OP_LEFT;
        ctl.color = (phase_r < 5'd20) ? wave_color(phase_r) : rgb_t'('0);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cur_mode_nxt  = cur_mode_r;
    pend_mode_nxt = pend_mode_r;
    phase_nxt     = phase_r;
    pct_nxt       = pct_r;
    lit_nxt       = lit_r;
    idx_nxt       = idx_r;
    power_nxt     = power_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_tuser) begin
          pct_nxt = in_pct;
          case (cur_mode_r)
            MODE_DISC: begin
              if (in_status == STAT_CHG) pend_mode_nxt = MODE_CHG;
              else if (in_status == STAT_FULL) pend_mode_nxt = MODE_FULL;
            end
            MODE_CHG: begin
              if (in_status == STAT_FULL || in_status == STAT_DISC) pend_mode_nxt = MODE_DROP;
            end
            MODE_FULL: begin
              if (in_status == STAT_CHG || in_status == STAT_DISC) pend_mode_nxt = MODE_DROP;
            end
            default: begin
              if (in_status == STAT_CHG) pend_mode_nxt = MODE_CHG;
              else if (in_status == STAT_FULL) pend_mode_nxt = MODE_FULL;
              else if (in_status == STAT_DISC) pend_mode_nxt = MODE_DISC;
            end
          endcase
        end else if (in_fire) begin
          state_nxt = ST_ACT;
          if (beat_commit) begin
            cur_mode_nxt = pend_mode_r;
            phase_nxt    = '0;
            if (pend_mode_r == MODE_CHG) lit_nxt = len_val;
            else if (pend_mode_r == MODE_FULL) lit_nxt = LIT_W'(PIXELS);
          end
        end
      end
      ST_ACT: begin
        state_nxt = ST_PWR;
        if (phase_r != '1) phase_nxt = phase_r + 1'b1;
      end
      ST_PWR: begin
        state_nxt = ST_EMIT;
        power_nxt = |bright;
        idx_nxt   = '0;
      end
      ST_EMIT: begin
        if (out_fire) begin
          idx_nxt = idx_r + 1'b1;
          if (last_idx) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_mode_r  <= MODE_DISC;
      pend_mode_r <= MODE_DISC;
      phase_r     <= '0;
      pct_r       <= '0;
      lit_r       <= '0;
      idx_r       <= '0;
      power_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_mode_r  <= cur_mode_nxt;
      pend_mode_r <= pend_mode_nxt;
      phase_r     <= phase_nxt;
      pct_r       <= pct_nxt;
      lit_r       <= lit_nxt;
      idx_r       <= idx_nxt;
      power_r     <= power_nxt;
    end
  end

  // cell i sees i-1 on the left and i+1 on the right, wrapping for the output rotation
  for (genvar i = 0; i < PIXELS; i++) begin : g_cell
    localparam int LI = (i == 0) ? PIXELS - 1 : i - 1;
    localparam int RI = (i == PIXELS - 1) ? 0 : i + 1;
    csla_cell #(
      .PIXELS (PIXELS),
      .IDX    (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .left_i   (pix[LI]),
      .right_i  (pix[RI]),
      .pix_o    (pix[i]),
      .bright_o (bright[i])
    );
  end

  assign out_tdata = {2'b00, pix[0].b, pix[0].g, pix[0].r, idx_r};
  assign out_tlast = last_idx;
  assign out_tuser = power_r;

endmodule

>>> rtl/csla_checker.sv
// port-level checks for the led strip animator, bound to the top level
`timescale 1ns / 1ps
`include "charge_state_led_strip_animator_defines.svh"
module csla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  `CSLA_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled pixel changed")
  `CSLA_ASSERT_NXT(a_beat_busy, in_tvalid && in_tready && in_tuser, !in_tready && !out_tvalid, "beat not sequenced")
  `CSLA_ASSERT_IMP(a_emit_busy, out_tvalid, !in_tready, "request taken while emitting")
  `CSLA_ASSERT_NXT(a_frame_end, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready, "frame did not end")

endmodule

bind charge_state_led_strip_animator csla_checker u_csla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
